// ===== rtl/bap_pkg.sv =====
// Shared constants, codes and types of the box-average image pyramid.
`timescale 1ns / 1ps

package bap_pkg;

  // Size limits of the pyramid.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_LEVELS = 6;
  localparam int MAX_HEIGHT = 4096;

  // Fixed field widths.
  localparam int DimW    = 13;
  localparam int PixW    = 8;
  localparam int LevelW  = 3;
  localparam int PosW    = 11;
  localparam int PairW   = 9;
  localparam int CfgIdxW = 2;

  // Widths that follow from the limits.
  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int RowW   = $clog2(MAX_HEIGHT);
  localparam int HalfAw = $clog2(MAX_WIDTH / 2);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgLevelCount  = 2'd2
  } cfg_reg_e;

  // A pixel traveling from one cell to the next.
  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] value;
  } tok_t;

  // Position of a finished pixel within its level.
  typedef struct packed {
    logic [PosW-1:0] column;
    logic [PosW-1:0] row;
  } pos_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic adv;
    logic clr;
    logic last_level;
  } cell_ctl_t;

  // Request from a cell to its line memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [HalfAw-1:0] addr;
    logic [PairW-1:0]  wdata;
  } ram_req_t;

  // One result pixel.
  typedef struct packed {
    logic [LevelW-1:0] level;
    pos_t              pos;
    logic [PixW-1:0]   pixel;
  } res_t;

endpackage

// ===== rtl/bap_if.sv =====
// Stream interfaces for the input pixel channel and the result channel.
`timescale 1ns / 1ps

interface bap_in_if import bap_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface bap_out_if import bap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic [PosW-1:0]   column;
  logic [PosW-1:0]   row;
  logic [PixW-1:0]   pixel_out;
  logic              last;

  modport source (output valid, output level, output column, output row,
                  output pixel_out, output last, input ready);
  modport sink (input valid, input level, input column, input row,
                input pixel_out, input last, output ready);
endinterface

// ===== rtl/box_average_image_pyramid.sv =====
// Top level of the streaming 2x2 box-average image pyramid.
//
//   channel  | dir | handshake          | payload
//   in_if    | in  | valid / ready      | pixel_in, frame_start
//   out_if   | out | valid / ready      | level, column, row, pixel_out, last
//   cfg      | in  | cfg_we_i (no wait) | cfg_idx_i, cfg_data_i
//
// One pixel is worked on at a time. It passes down the row of cells, one cell per level:
// a cell that finishes no level pixel registers its done flag; one that does first reads
// its line memory and then registers the level pixel.
// Reset clears the counters and left pixels; the line memories need no clearing.
// A stalled result beat stalls the whole row of cells; a new input beat is taken
// once the previous pixel has left the chain.
`timescale 1ns / 1ps

module box_average_image_pyramid import bap_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  bap_in_if.sink              in_if,
  bap_out_if.source           out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DimW-1:0]     cfg_data_i
);

  logic [DimW-1:0]   width_q, height_q;
  logic [LevelW-1:0] levels_q;

  logic [DimW-1:0]   width_c, height_c;
  logic [LevelW-1:0] levels_c;
  logic              enabled, cfg_clr, adv, accept;

  logic              busy_q, busy_d;
  logic              tok0_v_q, tok0_v_d;
  logic [PixW-1:0]   tok0_val_q;
  logic              tok0_fs_q;

  logic              pend_v_q, pend_v_d;
  res_t              pend_q, pend_d;
  logic              out_v_q, out_v_d;
  res_t              out_q, out_d;
  logic              out_last_q, out_last_d;

  tok_t              cell_tok_in [MAX_LEVELS];
  tok_t              cell_tok    [MAX_LEVELS];
  pos_t              cell_pos    [MAX_LEVELS];
  cell_ctl_t         cell_ctl    [MAX_LEVELS];
  ram_req_t          ram_req     [MAX_LEVELS];
  logic [PairW-1:0]  ram_rdata   [MAX_LEVELS];
  logic [DimW-1:0]   lvl_width   [MAX_LEVELS];
  logic [DimW-1:0]   lvl_height  [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] done_vec, emit_vec;

  logic              r_any, d_any;
  res_t              r_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      levels_q <= LevelW'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        CfgLevelCount:  levels_q <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_i)
      CfgImageWidth, CfgImageHeight, CfgLevelCount: cfg_clr = cfg_we_i;
      default: cfg_clr = 1'b0;
    endcase
  end

  // Clamped geometry and per-level sizes.
  always_comb begin
    width_c  = (int'(width_q) > MAX_WIDTH) ? DimW'(MAX_WIDTH) : width_q;
    height_c = (int'(height_q) > MAX_HEIGHT) ? DimW'(MAX_HEIGHT) : height_q;
    if (levels_q == '0) begin
      levels_c = LevelW'(1);
    end else if (int'(levels_q) > MAX_LEVELS) begin
      levels_c = LevelW'(MAX_LEVELS);
    end else begin
      levels_c = levels_q;
    end
    for (int s = 0; s < MAX_LEVELS; s++) begin
      lvl_width[s]  = width_c >> s;
      lvl_height[s] = height_c >> s;
    end
  end

  assign enabled = (width_q != '0) && (height_q != '0);
  assign adv     = !out_v_q || out_if.ready;
  assign accept  = in_if.valid && in_if.ready;
  assign in_if.ready = !busy_q;

  // Input register feeding the first cell.
  always_comb begin
    tok0_v_d = tok0_v_q;
    if (tok0_v_q && adv) begin
      tok0_v_d = 1'b0;
    end
    if (accept && enabled) begin
      tok0_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok0_val_q <= in_if.pixel_in;
      tok0_fs_q  <= in_if.frame_start;
    end
  end

  // Row of cells with one line memory each.
  for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_cell
    localparam int Depth = ((MAX_WIDTH >> (s + 1)) > 2) ? (MAX_WIDTH >> (s + 1)) : 2;
    localparam int Aw    = $clog2(Depth);

    if (s == 0) begin : g_first
      assign cell_tok_in[s].valid = tok0_v_q;
      assign cell_tok_in[s].value = tok0_val_q;
    end else begin : g_next
      assign cell_tok_in[s] = cell_tok[s-1];
    end

    assign cell_ctl[s].adv        = adv;
    assign cell_ctl[s].clr        = cfg_clr || (tok0_v_q && tok0_fs_q && adv);
    assign cell_ctl[s].last_level = ((s + 1) >= int'(levels_c));
    assign emit_vec[s]            = cell_tok[s].valid;

    bap_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl[s]),
      .width_i     (lvl_width[s]),
      .height_i    (lvl_height[s]),
      .tok_i       (cell_tok_in[s]),
      .tok_o       (cell_tok[s]),
      .pos_o       (cell_pos[s]),
      .done_o      (done_vec[s]),
      .ram_req_o   (ram_req[s]),
      .ram_rdata_i (ram_rdata[s])
    );

    bap_ram #(
      .DEPTH (Depth),
      .WIDTH (PairW)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (ram_req[s].we),
      .re_i    (ram_req[s].re),
      .addr_i  (ram_req[s].addr[Aw-1:0]),
      .wdata_i (ram_req[s].wdata),
      .rdata_o (ram_rdata[s])
    );
  end

  // Collect a finished pixel from whichever cell has one.
  always_comb begin
    r_any = 1'b0;
    r_res = '0;
    for (int s = 0; s < MAX_LEVELS; s++) begin
      if (cell_tok[s].valid) begin
        r_any       = 1'b1;
        r_res.level = LevelW'(s + 1);
        r_res.pos   = cell_pos[s];
        r_res.pixel = cell_tok[s].value;
      end
    end
  end

  assign d_any = |done_vec;

  // A result waits in the pending slot until it is known whether another follows.
  always_comb begin
    busy_d     = busy_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !out_if.ready;
    out_d      = out_q;
    out_last_d = out_last_q;

    if (accept && enabled) begin
      busy_d = 1'b1;
    end

    if (adv) begin
      if (r_any) begin
        if (pend_v_q) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b0;
        end
        pend_v_d = 1'b1;
        pend_d   = r_res;
      end
      if (d_any) begin
        if (pend_v_q) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b1;
        end
        pend_v_d = 1'b0;
        busy_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      tok0_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      tok0_v_q <= tok0_v_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_if.valid     = out_v_q;
  assign out_if.level     = out_q.level;
  assign out_if.column    = out_q.pos.column;
  assign out_if.row       = out_q.pos.row;
  assign out_if.pixel_out = out_q.pixel;
  assign out_if.last      = out_last_q;

  // Only one pixel is in the chain, so at most one cell offers a result.
  a_emit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(emit_vec))
    else $error("more than one cell offers a result");

  // A chain end and a new result never meet in one cycle.
  a_done_vs_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(r_any && d_any))
    else $error("chain end coincides with a result");

  // A loaded input pixel belongs to an item in progress.
  a_tok_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok0_v_q |-> busy_q)
    else $error("input pixel loaded while idle");

  // Nothing waits in the pending slot once the item has finished.
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> busy_q)
    else $error("pending result left after the item finished");

endmodule

// ===== rtl/bap_ram.sv =====
// Single-port line memory with registered read data.
`timescale 1ns / 1ps

module bap_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: a write or a read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bap_cell.sv =====
// One pyramid cell: position counters, left pixel and pair-sum logic of one source level.
`timescale 1ns / 1ps

module bap_cell import bap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [DimW-1:0]  width_i,
  input  logic [DimW-1:0]  height_i,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  output pos_t             pos_o,
  output logic             done_o,
  output ram_req_t         ram_req_o,
  input  logic [PairW-1:0] ram_rdata_i
);

  localparam int SumW = PairW + 2;

  logic [ColW-1:0]  col_q, col_d, col_cur;
  logic [RowW-1:0]  row_q, row_d, row_cur;
  logic [PixW-1:0]  left_q, left_d;
  logic             wait_q, wait_d;
  logic             emit_q, emit_d;
  logic             done_q, done_d;
  logic [PixW-1:0]  val_q, val_d;
  logic [PairW-1:0] pair_q, pair_d;
  pos_t             pos_q, pos_d;

  logic [DimW-1:0]  col_nx, row_nx;
  logic             in_area;
  logic [PairW-1:0] pair;
  logic [SumW-1:0]  sum;

  // Step the counters on a pixel, then store, write or read the pair sum.
  always_comb begin
    col_cur   = ctl_i.clr ? '0 : col_q;
    row_cur   = ctl_i.clr ? '0 : row_q;
    col_d     = col_cur;
    row_d     = row_cur;
    left_d    = left_q;
    wait_d    = wait_q;
    emit_d    = emit_q;
    done_d    = done_q;
    val_d     = val_q;
    pair_d    = pair_q;
    pos_d     = pos_q;
    ram_req_o = '0;

    col_nx  = DimW'(col_cur) + DimW'(1);
    row_nx  = DimW'(row_cur) + DimW'(1);
    in_area = (DimW'(col_cur) < {width_i[DimW-1:1], 1'b0})
           && (DimW'(row_cur) < {height_i[DimW-1:1], 1'b0});
    pair    = PairW'(left_q) + PairW'(tok_i.value);
    sum     = SumW'(ram_rdata_i) + SumW'(pair_q) + SumW'(2);

    if (ctl_i.adv) begin
      emit_d = 1'b0;
      done_d = 1'b0;

      // Second half of a finished block: the upper pair sum is back from memory.
      if (wait_q) begin
        val_d  = PixW'(sum >> 2);
        emit_d = 1'b1;
        wait_d = 1'b0;
      end

      if (tok_i.valid) begin
        if (col_nx >= width_i) begin
          col_d = '0;
          row_d = (row_nx >= height_i) ? '0 : RowW'(row_nx);
        end else begin
          col_d = ColW'(col_nx);
        end

        if (ctl_i.last_level || !in_area) begin
          done_d = 1'b1;
        end else if (!col_cur[0]) begin
          left_d = tok_i.value;
          done_d = 1'b1;
        end else if (!row_cur[0]) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = HalfAw'(col_cur >> 1);
          ram_req_o.wdata = pair;
          done_d          = 1'b1;
        end else begin
          ram_req_o.re = 1'b1;
          ram_req_o.addr = HalfAw'(col_cur >> 1);
          pair_d       = pair;
          pos_d.column = PosW'(col_cur >> 1);
          pos_d.row    = PosW'(row_cur >> 1);
          wait_d       = 1'b1;
        end
      end
    end
  end

  // Control and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      wait_q <= 1'b0;
      emit_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
      wait_q <= wait_d;
      emit_q <= emit_d;
      done_q <= done_d;
    end
  end

  // Payload of the block in progress and of the finished pixel.
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pair_q <= pair_d;
    pos_q  <= pos_d;
  end

  assign tok_o.valid = emit_q;
  assign tok_o.value = val_q;
  assign pos_o       = pos_q;
  assign done_o      = done_q;

endmodule

// ===== sim/pyramid_result_check.sv =====
// Predicts the pyramid results of each accepted pixel beat and checks the result beats.
`timescale 1ns / 1ps

module pyramid_result_check import bap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  bap_in_if                  in_if,
  bap_out_if                 out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i,
  output int                 mismatches_o,
  output int                 results_pending_o
);

  // One expected level pixel.
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [PosW-1:0]   column;
    logic [PosW-1:0]   row;
    logic [PixW-1:0]   pixel;
    logic              last;
  } level_pixel_t;

  level_pixel_t expected_level_pixels[$];
  int           mismatches;

  // Shadow of the configuration registers.
  logic [DimW-1:0] img_width;
  logic [DimW-1:0] img_height;
  logic [2:0]      lvl_count;

  // Shadow of the line stores, left pixels and position counters.
  logic [PairW-1:0] pair_sums [MAX_WIDTH];
  logic [PixW-1:0]  left_pix [MAX_LEVELS];
  int unsigned      col_pos [MAX_LEVELS];
  int unsigned      row_pos [MAX_LEVELS];

  assign mismatches_o = mismatches;

  function automatic void clear_positions();
    for (int s = 0; s < MAX_LEVELS; s++) begin
      col_pos[s] = 0;
      row_pos[s] = 0;
    end
  endfunction

  // Walks one source pixel down the levels and queues every level pixel it completes.
  task automatic compute_pyramid_pixels(input logic [PixW-1:0] pix, input logic starts_frame);
    int unsigned  lvl_w [MAX_LEVELS];
    int unsigned  lvl_h [MAX_LEVELS];
    int unsigned  depth;
    int unsigned  col;
    int unsigned  row;
    int unsigned  val;
    int unsigned  pair;
    int unsigned  idx;
    int unsigned  block_sum;
    int           produced;
    bit           done;
    level_pixel_t res;
    if (img_width == 0 || img_height == 0) return;
    lvl_w[0] = (img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
    lvl_h[0] = (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
    for (int s = 1; s < MAX_LEVELS; s++) begin
      lvl_w[s] = lvl_w[s-1] >> 1;
      lvl_h[s] = lvl_h[s-1] >> 1;
    end
    depth = (lvl_count == 0) ? 1 : lvl_count;
    if (depth > MAX_LEVELS) depth = MAX_LEVELS;
    if (starts_frame) clear_positions();
    val = pix;
    produced = 0;
    done = 1'b0;
    for (int s = 0; s < MAX_LEVELS && !done; s++) begin
      col = col_pos[s];
      row = row_pos[s];
      // Advance this level's position, wrapping at the end of the frame.
      if (col + 1 >= lvl_w[s]) begin
        col_pos[s] = 0;
        row_pos[s] = (row + 1 >= lvl_h[s]) ? 0 : row + 1;
      end else begin
        col_pos[s] = col + 1;
      end
      if (s + 1 >= depth) begin
        done = 1'b1;
      end else if (col >= 2 * lvl_w[s+1] || row >= 2 * lvl_h[s+1]) begin
        // Odd trailing column or row is dropped.
        done = 1'b1;
      end else if ((col & 1) == 0) begin
        left_pix[s] = val[PixW-1:0];
        done = 1'b1;
      end else begin
        pair = left_pix[s] + val;
        idx = MAX_WIDTH - (MAX_WIDTH >> s) + (col >> 1);
        if (idx >= MAX_WIDTH) begin
          done = 1'b1;
        end else if ((row & 1) == 0) begin
          pair_sums[idx] = pair[PairW-1:0];
          done = 1'b1;
        end else begin
          block_sum = pair_sums[idx] + pair;
          val = ((block_sum + 2) >> 2) & 8'hFF;
          res.level = LevelW'(s + 1);
          res.column = PosW'(col >> 1);
          res.row = PosW'(row >> 1);
          res.pixel = val[PixW-1:0];
          res.last = 1'b0;
          expected_level_pixels.push_back(res);
          produced++;
        end
      end
    end
    // The final level pixel of this beat carries the last flag.
    if (produced > 0) begin
      res = expected_level_pixels.pop_back();
      res.last = 1'b1;
      expected_level_pixels.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    level_pixel_t want;
    if (!rst_ni) begin
      expected_level_pixels.delete();
      mismatches = 0;
      img_width = '0;
      img_height = '0;
      lvl_count = 3'd5;
      for (int i = 0; i < MAX_WIDTH; i++) pair_sums[i] = '0;
      for (int s = 0; s < MAX_LEVELS; s++) left_pix[s] = '0;
      clear_positions();
      results_pending_o <= 0;
    end else begin
      // Results first: a beat leaving now never belongs to the beat entering now.
      if (out_if.valid && out_if.ready) begin
        if (expected_level_pixels.size() == 0) begin
          mismatches++;
          $display({"%0t: unexpected result, expected none actual level %0d col %0d",
                    " row %0d pixel %0d last %0d"},
                   $time, out_if.level, out_if.column, out_if.row, out_if.pixel_out,
                   out_if.last);
        end else begin
          want = expected_level_pixels.pop_front();
          check_field("level", 16'(want.level), 16'(out_if.level));
          check_field("column", 16'(want.column), 16'(out_if.column));
          check_field("row", 16'(want.row), 16'(out_if.row));
          check_field("pixel_out", 16'(want.pixel), 16'(out_if.pixel_out));
          check_field("last", 16'(want.last), 16'(out_if.last));
        end
      end
      if (in_if.valid && in_if.ready) begin
        compute_pyramid_pixels(in_if.pixel_in, in_if.frame_start);
      end
      // A write to a known register also restarts every position counter.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageWidth: begin
            img_width = cfg_data_i;
            clear_positions();
          end
          CfgImageHeight: begin
            img_height = cfg_data_i;
            clear_positions();
          end
          CfgLevelCount: begin
            lvl_count = cfg_data_i[2:0];
            clear_positions();
          end
          default: ;
        endcase
      end
      results_pending_o <= expected_level_pixels.size();
    end
  end

endmodule

// ===== sim/box_average_image_pyramid_tb.sv =====
// Top of the pyramid testbench: clock, reset, pixel stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module box_average_image_pyramid_tb import bap_pkg::*; ();

  localparam int                 RANDOM_ITEMS = 180;
  localparam int                 CYCLE_LIMIT  = 500000;
  localparam int                 SETTLE       = 16;
  localparam int                 LONG_HOLD    = 150;
  localparam int                 HOLD_PHASE   = 1;
  localparam int                 BIG_PHASE    = 2;
  localparam int                 PAUSE_PHASE  = 3;
  localparam logic [CfgIdxW-1:0] CfgUnused    = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DimW-1:0]    cfg_data;
  int                 mismatches;
  int                 results_pending;
  int                 cycles = 0;
  int                 hold_req = 0;
  bit                 quiet = 1'b0;

  bap_in_if  in_if ();
  bap_out_if out_if ();

  box_average_image_pyramid dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pyramid_result_check u_result_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_if             (in_if),
    .out_if            (out_if),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .mismatches_o      (mismatches),
    .results_pending_o (results_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result back-pressure: random stall bursts, plus one long hold on request.
  initial begin
    int seen_hold;
    seen_hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_hold) begin
        seen_hold = hold_req;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one pixel beat, sometimes after an idle burst, and waits for its acceptance.
  task automatic send_pixel(input logic [PixW-1:0] pix, input logic starts_frame);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pixel_in <= pix;
    in_if.frame_start <= starts_frame;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stops offering and waits until every expected result is out and the chain is empty.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                              input logic [2:0] lc);
    write_reg(CfgImageWidth, w);
    write_reg(CfgImageHeight, h);
    write_reg(CfgLevelCount, DimW'(lc));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int              random_items;
    int              phase;
    int              frames;
    int              frame_len;
    int              n_items;
    bit              well_formed;
    bit              skip_start;
    logic [DimW-1:0] cur_w;
    logic [DimW-1:0] cur_h;
    logic [2:0]      cur_lc;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CfgImageWidth;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.pixel_in <= '0;
    in_if.frame_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset leaves width and height at zero, so these beats give nothing.
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b0);
    drain();

    // Two 2x2 frames under the reset level count; the second one wraps without a start.
    write_reg(CfgImageWidth, 13'd2);
    write_reg(CfgImageHeight, 13'd2);
    cfg_we <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_pixel((i < 4) ? 8'hFF : ((i == 7) ? 8'h01 : 8'h00), i == 0);
    end
    drain();

    // Widest image with a saturated level count, cut short by the next write.
    write_config(13'h1FFF, 13'd2, 3'd7);
    for (int i = 0; i < 4; i++) send_pixel(8'(i * 85), i == 0);
    drain();

    // Tallest image, odd width; the write has already cleared the counters.
    write_config(13'd3, 13'h1FFF, 3'd6);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFE, 1'b0);
    send_pixel(8'h7F, 1'b0);
    send_pixel(8'h80, 1'b0);
    drain();

    // Level count zero keeps only full resolution.
    write_config(13'd2, 13'd2, 3'd0);
    for (int i = 0; i < 4; i++) send_pixel(8'($urandom), i == 0);
    drain();

    // Random phases: mostly whole frames of random pixels, some broken sequences.
    random_items = 0;
    phase = 0;
    cur_w = 13'd4;
    cur_h = 13'd4;
    cur_lc = 3'd2;
    while (random_items < RANDOM_ITEMS || phase <= PAUSE_PHASE || !quiet) begin
      if (phase == HOLD_PHASE) begin
        // Any held result stalls the chain, so a small frame fills the block.
        cur_w = 13'd4;
        cur_h = 13'd4;
        cur_lc = 3'd3;
        write_config(cur_w, cur_h, cur_lc);
        hold_req <= hold_req + 1;
      end else if (phase == BIG_PHASE) begin
        // A saturated level count over a frame that reaches three levels.
        cur_w = 13'd8;
        cur_h = 13'd8;
        cur_lc = 3'd7;
        write_config(cur_w, cur_h, cur_lc);
      end else if (phase == 0 || $urandom_range(0, 4) != 0) begin
        cur_w = ($urandom_range(0, 11) == 0) ? 13'd0 : DimW'($urandom_range(1, 9));
        cur_h = ($urandom_range(0, 11) == 0) ? 13'd0 : DimW'($urandom_range(1, 9));
        cur_lc = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(2, 6));
        write_config(cur_w, cur_h, cur_lc);
      end else begin
        // An unused register index must leave the counters where they are.
        write_reg(CfgUnused, DimW'($urandom));
        cfg_we <= 1'b0;
      end
      if (phase > PAUSE_PHASE && random_items >= RANDOM_ITEMS - 50) quiet = 1'b1;
      if (phase == BIG_PHASE || phase == HOLD_PHASE) begin
        frames = 1;
      end else if (phase == PAUSE_PHASE) begin
        frames = 2;
      end else begin
        frames = $urandom_range(1, 2);
      end
      frame_len = ((cur_w == 0) ? 1 : cur_w) * ((cur_h == 0) ? 1 : cur_h);
      for (int f = 0; f < frames; f++) begin
        well_formed = (phase == BIG_PHASE) || (phase == HOLD_PHASE)
                   || ($urandom_range(0, 3) != 0);
        skip_start = (f > 0) && ($urandom_range(0, 3) == 0);
        n_items = well_formed ? frame_len : $urandom_range(1, frame_len);
        for (int i = 0; i < n_items; i++) begin
          if (well_formed) begin
            send_pixel(8'($urandom), (i == 0) && !skip_start);
          end else begin
            send_pixel(8'($urandom), $urandom_range(0, 5) == 0);
          end
        end
        random_items += n_items;
        // Sender pause until every result is out, without touching the registers.
        if (phase == PAUSE_PHASE && f == 0) drain();
      end
      drain();
      phase++;
    end

    drain();
    if (mismatches == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
